// ===== hdl/vccr_pkg.sv =====
// Shared types, register map and attribute table of the custom-chip register block.
package vccr_pkg;

	// Item operations
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_LINE_LENGTH = 2'd0;
	localparam logic [1:0] CFG_FRAME_LINES = 2'd1;

	localparam logic [7:0] LINE_LENGTH_RESET = 8'd227;
	localparam logic [8:0] FRAME_LINES_RESET = 9'd313;

	// Attribute bits per register word
	localparam logic [3:0] KIND_R = 4'h1;
	localparam logic [3:0] KIND_W = 4'h2;
	localparam logic [3:0] KIND_S = 4'h4;
	localparam logic [3:0] KIND_H = 4'h8;

	// Register byte addresses (even byte of each word)
	localparam logic [11:0] A_DMACONR = 12'h002;
	localparam logic [11:0] A_VPOSR   = 12'h004;
	localparam logic [11:0] A_VHPOSR  = 12'h006;
	localparam logic [11:0] A_ADKCONR = 12'h010;
	localparam logic [11:0] A_POTGOR  = 12'h016;
	localparam logic [11:0] A_DSKBYTR = 12'h01A;
	localparam logic [11:0] A_INTENAR = 12'h01C;
	localparam logic [11:0] A_INTREQR = 12'h01E;
	localparam logic [11:0] A_DSKLEN  = 12'h024;
	localparam logic [11:0] A_POTGO   = 12'h034;
	localparam logic [11:0] A_BLTSIZE = 12'h058;
	localparam logic [11:0] A_COP1LC  = 12'h080;
	localparam logic [11:0] A_COP2LC  = 12'h084;
	localparam logic [11:0] A_COPJMP1 = 12'h088;
	localparam logic [11:0] A_COPJMP2 = 12'h08A;
	localparam logic [11:0] A_DMACON  = 12'h096;
	localparam logic [11:0] A_INTENA  = 12'h09A;
	localparam logic [11:0] A_INTREQ  = 12'h09C;
	localparam logic [11:0] A_ADKCON  = 12'h09E;

	localparam logic [11:0] MAP_END = 12'h200;
	localparam logic [15:0] VBLANK_BIT = 16'h0020;

	// One result item
	typedef struct packed {
		logic [7:0]  read_data;
		logic        line_end;
		logic        frame_start;
		logic        copper_load;
		logic [18:0] copper_address;
		logic        blit_start;
		logic        disk_length_write;
		logic [15:0] disk_length;
	} res_t;

	// Attribute table per register word; later ranges override earlier ones
	function automatic logic [3:0] attr_kind(input logic [7:0] w);
		logic [3:0] k;
		k = 4'h0;
		if (w <= 8'd15) k = KIND_R;
		if (w == 8'd2 || w == 8'd3 || w == 8'd13) k = KIND_R | KIND_H;
		if (w >= 8'd16 && w <= 8'd27) k = KIND_W;
		if (w == 8'd18 || w == 8'd26) k = KIND_W | KIND_H;
		if (w >= 8'd28 && w <= 8'd31) k = KIND_S;
		if (w >= 8'd32 && w <= 8'd44) k = KIND_W;
		if (w == 8'd44) k = KIND_W | KIND_H;
		if (w >= 8'd48 && w <= 8'd51) k = KIND_W;
		if (w >= 8'd56 && w <= 8'd58) k = KIND_W;
		if (w == 8'd60) k = KIND_W;
		if (w >= 8'd63 && w <= 8'd67) k = KIND_W;
		if (w == 8'd68 || w == 8'd69) k = KIND_S | KIND_H;
		if (w >= 8'd70 && w <= 8'd79) k = KIND_W;
		if (w == 8'd75) k = KIND_W | KIND_H;
		if (w >= 8'd77 && w <= 8'd79) k = KIND_W | KIND_H;
		if (w >= 8'd80 && w <= 8'd85) k = KIND_W;
		if (w >= 8'd88 && w <= 8'd93) k = KIND_W;
		if (w >= 8'd96 && w <= 8'd101) k = KIND_W;
		if (w >= 8'd104 && w <= 8'd109) k = KIND_W;
		if (w >= 8'd112 && w <= 8'd123) k = KIND_W;
		if (w >= 8'd128 && w <= 8'd130) k = KIND_W;
		if (w == 8'd132 || w == 8'd133) k = KIND_W;
		if (w >= 8'd136 && w <= 8'd141) k = KIND_W;
		if (w >= 8'd144 && w <= 8'd223) k = KIND_W;
		return k;
	endfunction

endpackage

// ===== hdl/video_custom_chip_register_block.sv =====
// Top level: custom-chip register block with a two-entry result queue.
// Each request (beam tick, byte read or byte write) is handled as it is accepted and its result
// is registered into the result queue; one request per clock is sustained as long as results
// are taken. A two-entry result queue decouples the sides: in_stall rises only when two results
// are waiting. There is no clearing pass after reset; the block is ready at once.
module video_custom_chip_register_block import vccr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [11:0] address,
	input  logic [7:0]  write_data,
	input  logic        disk_on_sync,
	input  logic        right_button_up,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        line_end,
	output logic        frame_start,
	output logic        copper_load,
	output logic [18:0] copper_address,
	output logic        blit_start,
	output logic        disk_length_write,
	output logic [15:0] disk_length,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	res_t       res, e0_q, e1_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_stall  = cnt_q == 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign push = in_valid && !in_stall;
	assign pop  = out_valid && !out_stall;

	vccr_core u_core (
		.clk, .arst_n, .push, .opcode, .address, .write_data, .disk_on_sync,
		.right_button_up, .cfg_we, .cfg_index, .cfg_data, .res
	);

	// Queue occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Queue payload; head entry drives the outputs
	always_ff @(posedge clk) begin
		case (cnt_q)
			2'd0: if (push) e0_q <= res;
			2'd1: begin
				if (push && pop) e0_q <= res;
				else if (push) e1_q <= res;
			end
			2'd2: if (pop) e0_q <= e1_q;
			default: ;
		endcase
	end

	assign read_data         = e0_q.read_data;
	assign line_end          = e0_q.line_end;
	assign frame_start       = e0_q.frame_start;
	assign copper_load       = e0_q.copper_load;
	assign copper_address    = e0_q.copper_address;
	assign blit_start        = e0_q.blit_start;
	assign disk_length_write = e0_q.disk_length_write;
	assign disk_length       = e0_q.disk_length;

endmodule

// ===== hdl/vccr_core.sv =====
// Register state, beam counters and per-request result logic.
module vccr_core import vccr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [1:0]  opcode,
	input  logic [11:0] address,
	input  logic [7:0]  write_data,
	input  logic        disk_on_sync,
	input  logic        right_button_up,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	output res_t        res
);

	logic [7:0]  line_length_q;
	logic [8:0]  frame_lines_q;
	logic [7:0]  h_q;
	logic [8:0]  v_q;
	logic        short_q;
	logic [15:0] dmaconr_q, intenar_q, intreqr_q, adkconr_q;
	logic [7:0]  potgor_q;
	logic [7:0]  dmacon_hi_q, intena_hi_q, intreq_hi_q, adkcon_hi_q, dsklen_hi_q;
	logic [7:0]  cop1_b1_q, cop1_b2_q, cop1_b3_q, cop2_b1_q, cop2_b2_q, cop2_b3_q;

	logic [7:0]  h_d;
	logic [8:0]  v_d;
	logic        short_d;
	logic [15:0] dmaconr_d, intenar_d, intreqr_d, adkconr_d;
	logic [7:0]  potgor_d;

	logic [11:0] reg_a;
	logic        odd, mapped;
	logic [3:0]  kind;
	logic [7:0]  len;
	logic [8:0]  h_inc;
	logic [9:0]  v_inc;
	logic [18:0] cop1_addr, cop2_addr;
	logic [7:0]  dskbytr_hi;
	logic [15:0] ctrl_w;

	// Set or clear a shadow word by a control word
	function automatic logic [15:0] set_clear(input logic [15:0] w, input logic [15:0] s);
		return w[15] ? (s | {1'b0, w[14:0]}) : (s & ~w);
	endfunction

	assign reg_a  = {address[11:1], 1'b0};
	assign odd    = address[0];
	assign mapped = address < MAP_END;
	assign kind   = attr_kind(address[8:1]);
	assign len    = short_q ? line_length_q - 8'd1 : line_length_q;
	assign h_inc  = {1'b0, h_q} + 9'd1;
	assign v_inc  = {1'b0, v_q} + 10'd1;
	assign cop1_addr = {cop1_b1_q[2:0], cop1_b2_q, cop1_b3_q[7:1], 1'b0};
	assign cop2_addr = {cop2_b1_q[2:0], cop2_b2_q, cop2_b3_q[7:1], 1'b0};
	assign ctrl_w = {8'h00, write_data};

	// Disk status high byte
	always_comb begin
		dskbytr_hi = 8'h00;
		dskbytr_hi[6] = dmaconr_q[9] & dmaconr_q[4] & dsklen_hi_q[7];
		dskbytr_hi[5] = dsklen_hi_q[6];
		dskbytr_hi[4] = disk_on_sync;
	end

	// Result and next state for one request
	always_comb begin
		res = '0;
		h_d = h_q;
		v_d = v_q;
		short_d = short_q;
		dmaconr_d = dmaconr_q;
		intenar_d = intenar_q;
		intreqr_d = intreqr_q;
		adkconr_d = adkconr_q;
		potgor_d = potgor_q;
		case (opcode)
			OP_TICK: begin
				if (h_inc <= {1'b0, len}) begin
					h_d = h_inc[7:0];
				end else begin
					res.line_end = 1'b1;
					short_d = ~short_q;
					h_d = 8'd0;
					if (v_inc >= {1'b0, frame_lines_q}) begin
						v_d = 9'd0;
						intreqr_d = intreqr_q | VBLANK_BIT;
						short_d = 1'b1;
						res.frame_start = 1'b1;
						res.copper_load = 1'b1;
						res.copper_address = cop1_addr;
					end else begin
						v_d = v_inc[8:0];
					end
				end
			end
			OP_READ: begin
				if (mapped && (kind & KIND_R) != 4'h0) begin
					case (reg_a)
						A_DMACONR: res.read_data = odd ? dmaconr_q[7:0] : dmaconr_q[15:8];
						A_VPOSR:   res.read_data = odd ? {7'd0, v_q[8]} : 8'h00;
						A_VHPOSR:  res.read_data = odd ? h_q : v_q[7:0];
						A_ADKCONR: res.read_data = odd ? adkconr_q[7:0] : adkconr_q[15:8];
						A_POTGOR:  res.read_data = odd ? 8'h00 : potgor_q;
						A_DSKBYTR: res.read_data = odd ? 8'h00 : dskbytr_hi;
						A_INTENAR: res.read_data = odd ? intenar_q[7:0] : intenar_q[15:8];
						A_INTREQR: res.read_data = odd ? intreqr_q[7:0] : intreqr_q[15:8];
						default:   res.read_data = 8'h00;
					endcase
				end
			end
			OP_WRITE: begin
				if (mapped && (kind & KIND_S) != 4'h0) begin
					if (reg_a == A_COPJMP1 || reg_a == A_COPJMP2) begin
						res.copper_load = 1'b1;
						res.copper_address = (reg_a == A_COPJMP1) ? cop1_addr : cop2_addr;
					end
				end else if (mapped && (kind & KIND_W) != 4'h0 && odd) begin
					case (reg_a)
						A_DMACON: dmaconr_d = set_clear({dmacon_hi_q, write_data}, dmaconr_q);
						A_INTENA: intenar_d = set_clear({intena_hi_q, write_data}, intenar_q);
						A_INTREQ: intreqr_d = set_clear({intreq_hi_q, write_data}, intreqr_q);
						A_ADKCON: adkconr_d = set_clear({adkcon_hi_q, write_data}, adkconr_q);
						A_BLTSIZE: res.blit_start = 1'b1;
						A_DSKLEN: begin
							res.disk_length_write = 1'b1;
							res.disk_length = {dsklen_hi_q, 8'h00} | ctrl_w;
						end
						default: ;
					endcase
				end else if (mapped && (kind & KIND_W) != 4'h0 && reg_a == A_POTGO) begin
					potgor_d = {5'd0, (write_data[3:2] == 2'b11) & right_button_up, 1'b0,
						write_data[1:0] == 2'b11};
				end
			end
			default: ;
		endcase
	end

	// Control state and shadows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= LINE_LENGTH_RESET;
			frame_lines_q <= FRAME_LINES_RESET;
			h_q <= '0;
			v_q <= '0;
			short_q <= 1'b1;
			dmaconr_q <= '0;
			intenar_q <= '0;
			intreqr_q <= '0;
			adkconr_q <= '0;
			potgor_q <= '0;
			dmacon_hi_q <= '0;
			intena_hi_q <= '0;
			intreq_hi_q <= '0;
			adkcon_hi_q <= '0;
			dsklen_hi_q <= '0;
			cop1_b1_q <= '0;
			cop1_b2_q <= '0;
			cop1_b3_q <= '0;
			cop2_b1_q <= '0;
			cop2_b2_q <= '0;
			cop2_b3_q <= '0;
		end else begin
			if (cfg_we && cfg_index == CFG_LINE_LENGTH) line_length_q <= cfg_data[7:0];
			if (cfg_we && cfg_index == CFG_FRAME_LINES) frame_lines_q <= cfg_data;
			if (push) begin
				h_q <= h_d;
				v_q <= v_d;
				short_q <= short_d;
				dmaconr_q <= dmaconr_d;
				intenar_q <= intenar_d;
				intreqr_q <= intreqr_d;
				adkconr_q <= adkconr_d;
				potgor_q <= potgor_d;
				// plain byte stores of the write-only words that are used later
				if (opcode == OP_WRITE) begin
					case (address)
						A_DMACON: dmacon_hi_q <= write_data;
						A_INTENA: intena_hi_q <= write_data;
						A_INTREQ: intreq_hi_q <= write_data;
						A_ADKCON: adkcon_hi_q <= write_data;
						A_DSKLEN: dsklen_hi_q <= write_data;
						A_COP1LC + 12'd1: cop1_b1_q <= write_data;
						A_COP1LC + 12'd2: cop1_b2_q <= write_data;
						A_COP1LC + 12'd3: cop1_b3_q <= write_data;
						A_COP2LC + 12'd1: cop2_b1_q <= write_data;
						A_COP2LC + 12'd2: cop2_b2_q <= write_data;
						A_COP2LC + 12'd3: cop2_b3_q <= write_data;
						default: ;
					endcase
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_frame_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		push && res.frame_start |-> res.line_end)
		else $error("frame start without line end");
	a_line_end_clears_h: assert property (@(posedge clk) disable iff (!arst_n)
		push && res.line_end |=> h_q == 8'd0)
		else $error("horizontal count not cleared at line end");
	a_frame_resets_v: assert property (@(posedge clk) disable iff (!arst_n)
		push && res.frame_start |=> v_q == 9'd0 && short_q && intreqr_q[5])
		else $error("frame wrap state wrong");
`endif

endmodule
